// ===== src/scf_pkg.sv =====
// Shared types and constants for the serial chain forward kinematics block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package scf_pkg;

    localparam int ACC_W = 67;  // sum of up to four 64-bit products plus rounding
    localparam int CZ_W  = 36;  // CORDIC angle, Q30 after fold
    localparam int CXY_W = 34;  // CORDIC x and y, Q30

    localparam logic [0:0] CFG_CHAIN_LEN = 1'b0;
    localparam logic [0:0] CFG_OUT_MODE  = 1'b1;

    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;
    localparam logic RES_JOINT  = 1'b0;
    localparam logic RES_POS    = 1'b1;

    localparam logic [3:0] SLOT_MIN  = 4'd12;
    localparam logic [3:0] SLOT_MAX  = 4'd13;
    localparam logic [3:0] SLOT_SIGN = 4'd14;
    localparam logic [3:0] SLOT_TYPE = 4'd15;

    localparam logic signed [31:0]    ONE_Q16      = 32'sd65536;
    localparam logic signed [33:0]    CLAMP_MARGIN = 34'sd410;   // 0.05 in Q3.13
    localparam logic signed [CXY_W-1:0] CORDIC_X0  = 34'sd652032874;
    localparam logic signed [CZ_W-1:0]  PI_Q30      = 36'sd3373259426;
    localparam logic signed [CZ_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic       rd_en;
        logic [3:0] rd_slot;
        logic [3:0] entry;
        logic [3:0] jidx;
        logic       ang_load;
        logic       do_clamp;
        logic       cord_init;
        logic       cord_step;
        logic [4:0] cord_iter;
        logic       cord_fin;
        logic       mul_step;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic       mul_first;
        logic       mul_last;
        logic       xf_init;
        logic       xf_commit;
        logic       emit_j;
        logic       emit_p;
        logic       emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_rot;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/scf_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`default_nettype none

interface scf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [3:0]         entry;
    logic [3:0]         slot;
    logic signed [31:0] table_value;
    logic signed [15:0] angle;
    logic               last;
    modport source(output valid, kind, entry, slot, table_value, angle, last, input ready);
    modport sink(input valid, kind, entry, slot, table_value, angle, last, output ready);
endinterface

interface scf_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [3:0]         joint_index;
    logic signed [15:0] joint_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_result;
    modport source(output valid, result_kind, joint_index, joint_angle, pos_x, pos_y, pos_z,
                   last_result, input ready);
    modport sink(input valid, result_kind, joint_index, joint_angle, pos_x, pos_y, pos_z,
                 last_result, output ready);
endinterface

`default_nettype wire

// ===== src/scf_dpath.sv =====
// Datapath: chain table memory, joint angles, clamp, CORDIC, affine MAC, output register.
// Depends on scf_pkg; driven by scf_ctrl commands.
`default_nettype none

module scf_dpath import scf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_in_fire,
    input  logic               i_in_kind,
    input  logic [3:0]         i_in_entry,
    input  logic [3:0]         i_in_slot,
    input  logic signed [31:0] i_in_value,
    input  logic signed [15:0] i_in_angle,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_res_kind,
    output logic [3:0]         o_joint_index,
    output logic signed [15:0] o_joint_angle,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic               o_last_result
);

    logic [31:0]        r_tbl [256];
    logic [31:0]        r_tbl_q;
    logic               r_rd_v;
    logic [3:0]         r_rd_slot;

    logic signed [15:0] r_jang [16];
    logic signed [31:0] r_b [12];
    logic signed [31:0] r_a [12];
    logic signed [31:0] r_r [12];
    logic signed [31:0] r_mn, r_mx;
    logic               r_sg, r_is_rot;
    logic signed [15:0] r_ang;

    logic signed [CZ_W-1:0]  r_z;
    logic signed [CXY_W-1:0] r_x, r_y;
    logic                    r_flip;

    logic signed [63:0]      r_p;
    logic                    r_p_v, r_p_first, r_p_last;
    logic [3:0]              r_p_dst;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_f_v;
    logic [3:0]              r_f_dst;

    logic                    r_ov;

    // clamp
    logic signed [33:0] cl_a;
    logic signed [15:0] cl_q;
    always_comb begin
        cl_a = 34'(r_jang[i_cmd.jidx]);
        if (cl_a < 34'(r_mn)) cl_a = 34'(r_mn) + CLAMP_MARGIN;
        if (cl_a > 34'(r_mx)) cl_a = 34'(r_mx) - CLAMP_MARGIN;
        if (cl_a > 34'sd32767)       cl_q = 16'sh7fff;
        else if (cl_a < -34'sd32768) cl_q = 16'sh8000;
        else                         cl_q = cl_a[15:0];
    end

    // CORDIC
    logic signed [16:0]       th;
    logic signed [CZ_W-1:0]   z0, at;
    logic signed [CXY_W-1:0]  dx, dy, xf, yf, cx, sy;
    logic signed [31:0]       c_q, s_q;
    always_comb begin
        th = r_sg ? -17'(r_ang) : 17'(r_ang);
        z0 = 36'(th) <<< 17;
        at = {6'd0, atan_q30(i_cmd.cord_iter)};
        dx = r_y >>> i_cmd.cord_iter;
        dy = r_x >>> i_cmd.cord_iter;
        xf = r_flip ? -r_x : r_x;
        yf = r_flip ? -r_y : r_y;
        cx = (xf + 34'sd8192) >>> 14;
        sy = (yf + 34'sd8192) >>> 14;
        c_q = cx[31:0];
        s_q = sy[31:0];
    end

    // MAC operand select; k of three is the translation term
    logic signed [31:0]      a_sel, b_sel;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [31:0]      sat_q;
    always_comb begin
        a_sel = r_a[{i_cmd.row, i_cmd.k}];
        b_sel = (i_cmd.k == 2'd3) ? ONE_Q16 : r_b[{i_cmd.k, i_cmd.col}];
        acc_sh = r_acc >>> 16;
        if (acc_sh > 67'sd2147483647)       sat_q = 32'sh7fffffff;
        else if (acc_sh < -67'sd2147483648) sat_q = 32'sh80000000;
        else                                sat_q = acc_sh[31:0];
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_in_kind == KIND_TABLE) r_tbl[{i_in_entry, i_in_slot}] <= i_in_value;
        if (i_cmd.rd_en) r_tbl_q <= r_tbl[{i_cmd.entry, i_cmd.rd_slot}];
        r_rd_slot <= i_cmd.rd_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_p_v  <= 1'b0;
            r_f_v  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            r_p_v  <= i_cmd.mul_step;
            r_f_v  <= r_p_v && r_p_last;
            if (i_cmd.emit_j || i_cmd.emit_p) r_ov <= 1'b1;
            else if (i_out_ready)            r_ov <= 1'b0;
        end
    end

    // entry words, angles, CORDIC and MAC payload
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            priority if (r_rd_slot < SLOT_MIN) r_b[r_rd_slot] <= r_tbl_q;
            else if (r_rd_slot == SLOT_MIN)    r_mn <= r_tbl_q;
            else if (r_rd_slot == SLOT_MAX)    r_mx <= r_tbl_q;
            else if (r_rd_slot == SLOT_SIGN)   r_sg <= r_tbl_q[31];
            else                               r_is_rot <= (r_tbl_q == 32'd1);
        end
        if (i_cmd.cord_fin) begin
            r_b[0]  <= c_q;   r_b[1]  <= -s_q;  r_b[2]  <= '0; r_b[3]  <= '0;
            r_b[4]  <= s_q;   r_b[5]  <= c_q;   r_b[6]  <= '0; r_b[7]  <= '0;
            r_b[8]  <= '0;    r_b[9]  <= '0;    r_b[10] <= ONE_Q16; r_b[11] <= '0;
        end

        if (i_in_fire && i_in_kind == KIND_ANGLE) r_jang[i_in_entry] <= i_in_angle;
        else if (i_cmd.ang_load && i_cmd.do_clamp) r_jang[i_cmd.jidx] <= cl_q;
        if (i_cmd.ang_load) r_ang <= i_cmd.do_clamp ? cl_q : r_jang[i_cmd.jidx];

        if (i_cmd.cord_init) begin
            r_x <= CORDIC_X0;
            r_y <= '0;
            if (z0 > HALF_PI_Q30) begin
                r_z <= z0 - PI_Q30; r_flip <= 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
                r_z <= z0 + PI_Q30; r_flip <= 1'b1;
            end else begin
                r_z <= z0; r_flip <= 1'b0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
            end
        end

        r_p       <= a_sel * b_sel;
        r_p_first <= i_cmd.mul_first;
        r_p_last  <= i_cmd.mul_last;
        r_p_dst   <= {i_cmd.row, i_cmd.col};
        if (r_p_v) r_acc <= (r_p_first ? 67'sd32768 : r_acc) + 67'(r_p);
        r_f_dst <= r_p_dst;
        if (r_f_v) r_r[r_f_dst] <= sat_q;

        for (int i = 0; i < 12; i++) begin
            if (i_cmd.xf_init)        r_a[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q16 : '0;
            else if (i_cmd.xf_commit) r_a[i] <= r_r[i];
        end

        if (i_cmd.emit_j) begin
            o_res_kind    <= RES_JOINT;
            o_joint_index <= i_cmd.jidx;
            o_joint_angle <= r_ang;
            o_pos_x <= '0; o_pos_y <= '0; o_pos_z <= '0;
            o_last_result <= 1'b0;
        end else if (i_cmd.emit_p) begin
            o_res_kind    <= RES_POS;
            o_joint_index <= i_cmd.entry;
            o_joint_angle <= '0;
            o_pos_x <= r_a[3]; o_pos_y <= r_a[7]; o_pos_z <= r_a[11];
            o_last_result <= i_cmd.emit_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_stat.is_rot   = r_is_rot;

endmodule

`default_nettype wire

// ===== src/scf_ctrl.sv =====
// Controller: config registers and the chain-walk state machine.
// Depends on scf_pkg; issues commands to scf_dpath.
`default_nettype none

module scf_ctrl import scf_pkg::*; #(
    parameter int MAX_CHAIN         = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    output t_dp_cmd    o_cmd,
    input  t_dp_stat   i_stat
);

    localparam int N_ITER = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam int CAP    = (MAX_CHAIN < 16) ? MAX_CHAIN : 16;
    localparam logic [4:0] LAST_IT = 5'(N_ITER - 1);
    localparam logic [4:0] CAP_L   = 5'(CAP);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_LOADW  = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_CLAMP  = 4'd4;
    localparam logic [3:0] S_EMIT_J = 4'd5;
    localparam logic [3:0] S_CINIT  = 4'd6;
    localparam logic [3:0] S_CITER  = 4'd7;
    localparam logic [3:0] S_CFIN   = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_D1     = 4'd10;
    localparam logic [3:0] S_D2     = 4'd11;
    localparam logic [3:0] S_COMMIT = 4'd12;
    localparam logic [3:0] S_EMIT_L = 4'd13;
    localparam logic [3:0] S_NEXT   = 4'd14;
    localparam logic [3:0] S_EMIT_T = 4'd15;

    logic [3:0] r_state, n_state;
    logic [4:0] r_len;
    logic       r_mode;
    logic [3:0] r_e, n_e, r_last_e, n_last_e, r_w, n_w;
    logic [4:0] r_rc, n_rc, r_it, n_it;
    logic [1:0] r_row, n_row, r_col, n_col, r_k, n_k;
    logic       fire;
    logic [4:0] lim;
    logic [1:0] k_end;

    assign fire  = i_in_valid && o_in_ready;
    assign k_end = (r_col == 2'd3) ? 2'd3 : 2'd2;

    always_comb begin
        lim = (r_len == 5'd0) ? 5'd1 : r_len;
        if (lim > CAP_L) lim = CAP_L;
    end

    always_comb begin
        n_state = r_state; n_e = r_e; n_last_e = r_last_e; n_w = r_w;
        n_rc = r_rc; n_it = r_it; n_row = r_row; n_col = r_col; n_k = r_k;
        o_cmd = '0;
        o_cmd.entry     = r_e;
        o_cmd.rd_slot   = r_w;
        o_cmd.jidx      = r_rc[3:0];
        o_cmd.do_clamp  = !r_mode;
        o_cmd.cord_iter = r_it;
        o_cmd.row = r_row; o_cmd.col = r_col; o_cmd.k = r_k;
        o_cmd.mul_first = (r_k == 2'd0);
        o_cmd.mul_last  = (r_k == k_end);
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (fire && i_in_kind == KIND_ANGLE && i_in_last) begin
                    o_cmd.xf_init = 1'b1;
                    n_last_e = 4'(lim - 5'd1);
                    n_e = '0; n_rc = '0; n_w = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.rd_en = 1'b1;
                n_w = r_w + 4'd1;
                if (r_w == SLOT_TYPE) n_state = S_LOADW;
            end
            S_LOADW: n_state = S_DECIDE;
            S_DECIDE: begin
                n_row = '0; n_col = '0; n_k = '0;
                n_state = i_stat.is_rot ? S_CLAMP : S_MUL;
            end
            S_CLAMP: begin
                o_cmd.ang_load = 1'b1;
                n_state = r_mode ? S_CINIT : S_EMIT_J;
            end
            S_EMIT_J: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_j = 1'b1;
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.cord_init = 1'b1;
                n_it = '0;
                n_state = S_CITER;
            end
            S_CITER: begin
                o_cmd.cord_step = 1'b1;
                n_it = r_it + 5'd1;
                if (r_it == LAST_IT) n_state = S_CFIN;
            end
            S_CFIN: begin
                o_cmd.cord_fin = 1'b1;
                n_rc = r_rc + 5'd1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_k != k_end) begin
                    n_k = r_k + 2'd1;
                end else begin
                    n_k = '0;
                    if (r_col != 2'd3) begin
                        n_col = r_col + 2'd1;
                    end else begin
                        n_col = '0;
                        n_row = r_row + 2'd1;
                        if (r_row == 2'd2) n_state = S_D1;
                    end
                end
            end
            S_D1: n_state = S_D2;
            S_D2: n_state = S_COMMIT;
            S_COMMIT: begin
                o_cmd.xf_commit = 1'b1;
                n_state = r_mode ? S_EMIT_L : S_NEXT;
            end
            S_EMIT_L: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_p    = 1'b1;
                    o_cmd.emit_last = (r_e == r_last_e);
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_e == r_last_e) begin
                    n_state = r_mode ? S_IDLE : S_EMIT_T;
                end else begin
                    n_e = r_e + 4'd1;
                    n_w = '0;
                    n_state = S_LOAD;
                end
            end
            S_EMIT_T: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_p    = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= 5'd1;
            r_mode  <= 1'b0;
            r_e <= '0; r_last_e <= '0; r_w <= '0; r_rc <= '0; r_it <= '0;
            r_row <= '0; r_col <= '0; r_k <= '0;
        end else begin
            r_state <= n_state;
            r_e <= n_e; r_last_e <= n_last_e; r_w <= n_w; r_rc <= n_rc; r_it <= n_it;
            r_row <= n_row; r_col <= n_col; r_k <= n_k;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CHAIN_LEN: r_len  <= i_cfg_data;
                    CFG_OUT_MODE:  r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_j || o_cmd.emit_p) |-> i_stat.out_free)
        else $error("result issued while output register occupied");
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_in_kind == KIND_ANGLE && i_in_last) |=> (r_state == S_LOAD && r_e == 4'd0))
        else $error("walk did not start at entry zero");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CITER) |-> (r_it <= LAST_IT))
        else $error("CORDIC iteration count overran");
    a_joint_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_j |-> !r_mode)
        else $error("joint result in per-link mode");
`endif

endmodule

`default_nettype wire

// ===== src/serial_chain_forward_kinematics.sv =====
// Top level of the serial chain forward kinematics block.
// Depends on scf_pkg, scf_if, scf_ctrl and scf_dpath.
//
//   channel  | dir | handshake     | payload
//   i_item   | in  | valid/ready   | kind, entry, slot, table_value, angle, last
//   o_res    | out | valid/ready   | result_kind, joint_index, joint_angle, pos_x/y/z, last_result
//   i_cfg_*  | in  | write enable  | i_cfg_idx, i_cfg_data
//
// Table writes and angles without last are taken while idle. For each entry a walk makes 16
// table-memory reads, runs the CORDIC loop if the entry is a rotation, and makes 39 serial
// MAC steps through one 32x32 multiplier.
// Input is not taken during a walk; a stalled output holds the walk at its next result.
// Reset is synchronous, active low; the table and joint angle stores are not cleared.
`default_nettype none

module serial_chain_forward_kinematics import scf_pkg::*; #(
    parameter int MAX_CHAIN         = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scf_in_if.sink     i_item,
    scf_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     fire;

    assign i_item.ready = in_ready;
    assign fire = i_item.valid && in_ready;

    scf_ctrl #(
        .MAX_CHAIN(MAX_CHAIN),
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_item.valid),
        .i_in_kind(i_item.kind),
        .i_in_last(i_item.last),
        .o_in_ready(in_ready),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_cmd(cmd),
        .i_stat(stat)
    );

    scf_dpath u_dpath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .o_stat(stat),
        .i_in_fire(fire),
        .i_in_kind(i_item.kind),
        .i_in_entry(i_item.entry),
        .i_in_slot(i_item.slot),
        .i_in_value(i_item.table_value),
        .i_in_angle(i_item.angle),
        .i_out_ready(o_res.ready),
        .o_out_valid(o_res.valid),
        .o_res_kind(o_res.result_kind),
        .o_joint_index(o_res.joint_index),
        .o_joint_angle(o_res.joint_angle),
        .o_pos_x(o_res.pos_x),
        .o_pos_y(o_res.pos_y),
        .o_pos_z(o_res.pos_z),
        .o_last_result(o_res.last_result)
    );

endmodule

`default_nettype wire
